// ----- hw/rtl/cmbt_pkg.sv -----
package cmbt_pkg;

    localparam int ROW_BITS = 16;
    localparam int POS_BITS = 32;
    localparam int LEN_BITS = 16;
    localparam int QDEPTH   = 4;
    localparam int QBITS    = $clog2(QDEPTH);

    localparam logic [4:0] K_ADJ    = 5'd0;
    localparam logic [4:0] K_UNCL   = 5'd1;
    localparam logic [4:0] K_KW     = 5'd2;
    localparam logic [4:0] K_ID     = 5'd3;
    localparam logic [4:0] K_NUM    = 5'd4;
    localparam logic [4:0] K_SPACE  = 5'd5;
    localparam logic [4:0] K_EOL    = 5'd6;
    localparam logic [4:0] K_LCOM   = 5'd7;
    localparam logic [4:0] K_BOPEN  = 5'd8;
    localparam logic [4:0] K_BCLOSE = 5'd9;
    localparam logic [4:0] K_LT     = 5'd10;
    localparam logic [4:0] K_LE     = 5'd11;
    localparam logic [4:0] K_GT     = 5'd12;
    localparam logic [4:0] K_GE     = 5'd13;
    localparam logic [4:0] K_EQ     = 5'd14;
    localparam logic [4:0] K_NEA    = 5'd15;
    localparam logic [4:0] K_NEB    = 5'd16;
    localparam logic [4:0] K_SYM    = 5'd17;

    typedef struct packed {
        logic [4:0]          kind;
        logic [2:0]          kw;
        logic [7:0]          sym;
        logic [ROW_BITS-1:0] row;
        logic [POS_BITS-1:0] start;
        logic [LEN_BITS-1:0] len;
        logic                last;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       t0;
        t_tok       t1;
    } t_pair;

endpackage

// ----- hw/rtl/c_minus_byte_tokenizer_top.sv -----
// byte tokenizer for a small c-like language
// input channel: i_valid/o_ready carries one source byte per beat with
// i_end_of_input on the final byte of a stream
// output channel: o_valid/i_ready carries one token per beat: kind, keyword
// index, symbol byte, row, start offset, saturating length, last_of_run
// a byte is taken every cycle while the token queue has room for two tokens;
// each byte gives zero, one or two tokens
// a token caused by a byte is registered in the token queue before it reaches the output
// throughput: one byte per cycle while o_ready is high and one token per cycle while
// i_ready is high; set by the single classify step in the front and the one-beat-per-cycle queue read
// a stalled receiver lets the four-entry queue fill past two entries, after
// which o_ready drops until it drains back to two; tokens are never dropped
// reset (synchronous, active low) empties the queue and returns the scanner
// to idle with row and offset at zero
module c_minus_byte_tokenizer_top import cmbt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_input,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [4:0]          o_token_kind,
    output logic [2:0]          o_keyword_index,
    output logic [7:0]          o_symbol_byte,
    output logic [ROW_BITS-1:0] o_row_number,
    output logic [POS_BITS-1:0] o_start_position,
    output logic [LEN_BITS-1:0] o_lexeme_length,
    output logic                o_last_of_run
);

    logic  space, push;
    t_pair pair;
    t_tok  tok;

    cmbt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_data_byte, .i_end_of_input,
        .i_space(space), .o_ready, .o_push(push), .o_pair(pair)
    );

    cmbt_back u_back (
        .i_clk, .i_rst_n, .i_push(push), .i_pair(pair), .o_space(space),
        .o_valid, .i_ready, .o_tok(tok)
    );

    assign o_token_kind     = tok.kind;
    assign o_keyword_index  = tok.kw;
    assign o_symbol_byte    = tok.sym;
    assign o_row_number     = tok.row;
    assign o_start_position = tok.start;
    assign o_lexeme_length  = tok.len;
    assign o_last_of_run    = tok.last;

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_token_kind <= K_SYM) else $error("bad token kind");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> space) else $error("push without room");
    a_kw_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind != K_KW) |-> o_keyword_index == 3'd0)
        else $error("stray keyword index");

endmodule

// ----- hw/rtl/cmbt_front.sv -----
module cmbt_front import cmbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    input  logic       i_space,
    output logic       o_ready,
    output logic       o_push,
    output t_pair      o_pair
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ALPHA = 6'b000010,
        S_DIGIT = 6'b000100,
        S_HELD  = 6'b001000,
        S_LINE  = 6'b010000,
        S_BLOCK = 6'b100000
    } t_mode;

    localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
    localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

    t_mode               r_mode, n_mode;
    logic [47:0]         r_win, n_win;
    logic [LEN_BITS-1:0] r_len, n_len;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [7:0]          r_held, n_held;
    logic                r_star, n_star;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic [POS_BITS-1:0] r_pos, n_pos;

    logic [7:0] b;
    logic is_l, is_d, is_blank, is_sym;
    logic [1:0] cnt;
    t_tok t0, t1;
    logic [LEN_BITS-1:0] one_len, two_len;

    assign b        = i_data_byte;
    assign is_l     = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    assign is_d     = b >= 8'h30 && b <= 8'h39;
    assign is_blank = b == 8'h20 || b == 8'h09;
    assign is_sym   = !is_l && !is_d && !is_blank && b != 8'h0a && b != 8'hff;
    assign one_len  = LEN_BITS'(1);
    assign two_len  = LEN_BITS'(2);
    assign o_ready  = i_space;

    // row is sampled at emit time, so tokens capture n_row as it stands when emitted
    always_comb begin
        logic          consumed;
        logic [4:0]    wk;
        logic [2:0]    wi;
        t_tok          e;
        n_mode = r_mode; n_win = r_win; n_len = r_len; n_start = r_start;
        n_held = r_held; n_star = r_star; n_row = r_row;
        n_pos = r_pos + POS_BITS'(1);
        consumed = 1'b1;
        cnt = 2'd0;
        t0 = '0; t1 = '0; e = '0;
        // keyword lookup on the current window
        wk = K_ID; wi = 3'd0;
        if (r_len == LEN_BITS'(2) && r_win == 48'h6966) begin
            wk = K_KW; wi = 3'd0;
        end else if (r_len == LEN_BITS'(4) && r_win == 48'h656C7365) begin
            wk = K_KW; wi = 3'd1;
        end else if (r_len == LEN_BITS'(3) && r_win == 48'h696E74) begin
            wk = K_KW; wi = 3'd2;
        end else if (r_len == LEN_BITS'(6) && r_win == 48'h72657475726E) begin
            wk = K_KW; wi = 3'd3;
        end else if (r_len == LEN_BITS'(4) && r_win == 48'h766F6964) begin
            wk = K_KW; wi = 3'd4;
        end else if (r_len == LEN_BITS'(5) && r_win == 48'h7768696C65) begin
            wk = K_KW; wi = 3'd5;
        end
        case (r_mode)
            S_ALPHA: begin
                if (is_l) begin
                    n_win = {r_win[39:0], b};
                    if (r_len != LEN_MAX) n_len = r_len + one_len;
                end else begin
                    e.kind = is_d ? K_ADJ : wk;
                    e.kw = is_d ? 3'd0 : wi;
                    e.row = n_row; e.start = r_start; e.len = r_len;
                    t0 = e; cnt = 2'd1;
                    n_mode = S_IDLE; consumed = 1'b0;
                end
            end
            S_DIGIT: begin
                if (is_d) begin
                    if (r_len != LEN_MAX) n_len = r_len + one_len;
                end else begin
                    e.kind = is_l ? K_ADJ : K_NUM;
                    e.row = n_row; e.start = r_start; e.len = r_len;
                    t0 = e; cnt = 2'd1;
                    n_mode = S_IDLE; consumed = 1'b0;
                end
            end
            S_HELD: begin
                e.row = n_row; e.start = r_start; e.len = two_len;
                n_mode = S_IDLE;
                if (is_sym) begin
                    cnt = 2'd1;
                    if (r_held == 8'h2f && b == 8'h2f) begin
                        e.kind = K_LCOM; n_mode = S_LINE;
                    end else if (r_held == 8'h2f && b == 8'h2a) begin
                        e.kind = K_BOPEN; n_mode = S_BLOCK; n_star = 1'b0; n_len = two_len;
                    end else if (r_held == 8'h3c && b == 8'h3d) e.kind = K_LE;
                    else if (r_held == 8'h3e && b == 8'h3d) e.kind = K_GE;
                    else if (r_held == 8'h3d && b == 8'h3d) e.kind = K_EQ;
                    else if (r_held == 8'h3c && b == 8'h3e) e.kind = K_NEA;
                    else if (r_held == 8'h21 && b == 8'h3d) e.kind = K_NEB;
                    else begin
                        e.kind = K_SYM; e.sym = r_held; e.len = one_len;
                        t1 = e; t1.sym = b; t1.start = r_pos;
                        cnt = 2'd2;
                    end
                    t0 = e;
                end else begin
                    e.len = one_len;
                    if (r_held == 8'h3c) e.kind = K_LT;
                    else if (r_held == 8'h3e) e.kind = K_GT;
                    else begin
                        e.kind = K_SYM; e.sym = r_held;
                    end
                    t0 = e; cnt = 2'd1; consumed = 1'b0;
                end
            end
            S_LINE: begin
                if (b == 8'h0a) begin
                    if (r_row != ROW_MAX) n_row = r_row + ROW_BITS'(1);
                    n_mode = S_IDLE;
                end
            end
            S_BLOCK: begin
                if (r_len != LEN_MAX) n_len = r_len + one_len;
                if (r_star && b == 8'h2f) begin
                    e.kind = K_BCLOSE; e.row = n_row;
                    e.start = r_pos - POS_BITS'(1); e.len = two_len;
                    t0 = e; cnt = 2'd1;
                    n_mode = S_IDLE; n_star = 1'b0;
                end else begin
                    n_star = b == 8'h2a;
                    if (b == 8'h0a && r_row != ROW_MAX) n_row = r_row + ROW_BITS'(1);
                end
            end
            default: begin
                n_mode = S_IDLE; consumed = 1'b0;
            end
        endcase
        if (!consumed) begin
            e = '0; e.row = n_row; e.start = r_pos; e.len = one_len;
            if (is_l) begin
                n_mode = S_ALPHA; n_start = r_pos; n_len = one_len; n_win = {40'd0, b};
            end else if (is_d) begin
                n_mode = S_DIGIT; n_start = r_pos; n_len = one_len;
            end else if (is_blank) begin
                e.kind = K_SPACE; e.sym = b;
                if (cnt == 2'd0) t0 = e; else t1 = e;
                cnt = cnt + 2'd1;
            end else if (b == 8'h0a) begin
                e.kind = K_EOL;
                if (cnt == 2'd0) t0 = e; else t1 = e;
                cnt = cnt + 2'd1;
                if (n_row != ROW_MAX) n_row = n_row + ROW_BITS'(1);
            end else if (b != 8'hff) begin
                n_mode = S_HELD; n_held = b; n_start = r_pos;
            end
        end
        if (i_end_of_input) begin
            e = '0; e.row = n_row; e.start = n_start; e.len = n_len;
            // at most two tokens per byte, so a flush never overflows
            case (n_mode)
                S_ALPHA: begin
                    e.kind = K_ID;
                    if (n_len == LEN_BITS'(2) && n_win == 48'h6966) begin
                        e.kind = K_KW; e.kw = 3'd0;
                    end else if (n_len == LEN_BITS'(4) && n_win == 48'h656C7365) begin
                        e.kind = K_KW; e.kw = 3'd1;
                    end else if (n_len == LEN_BITS'(3) && n_win == 48'h696E74) begin
                        e.kind = K_KW; e.kw = 3'd2;
                    end else if (n_len == LEN_BITS'(6) && n_win == 48'h72657475726E) begin
                        e.kind = K_KW; e.kw = 3'd3;
                    end else if (n_len == LEN_BITS'(4) && n_win == 48'h766F6964) begin
                        e.kind = K_KW; e.kw = 3'd4;
                    end else if (n_len == LEN_BITS'(5) && n_win == 48'h7768696C65) begin
                        e.kind = K_KW; e.kw = 3'd5;
                    end
                end
                S_DIGIT: e.kind = K_NUM;
                S_HELD: begin
                    e.len = one_len;
                    if (n_held == 8'h3c) e.kind = K_LT;
                    else if (n_held == 8'h3e) e.kind = K_GT;
                    else begin
                        e.kind = K_SYM; e.sym = n_held;
                    end
                end
                S_BLOCK: e.kind = K_UNCL;
                S_LINE: if (n_row != ROW_MAX) n_row = n_row + ROW_BITS'(1);
                default: ;
            endcase
            if (n_mode == S_ALPHA || n_mode == S_DIGIT || n_mode == S_HELD
                    || n_mode == S_BLOCK) begin
                if (cnt == 2'd0) t0 = e; else t1 = e;
                cnt = cnt + 2'd1;
            end
            n_mode = S_IDLE; n_star = 1'b0; n_pos = '0;
        end
        if (cnt == 2'd1) t0.last = 1'b1;
        if (cnt == 2'd2) t1.last = 1'b1;
    end

    assign o_push = i_valid && i_space && cnt != 2'd0;
    assign o_pair = '{cnt: cnt, t0: t0, t1: t1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= S_IDLE; r_win <= '0; r_len <= '0; r_start <= '0;
            r_held <= '0; r_star <= 1'b0; r_row <= '0; r_pos <= '0;
        end else if (i_valid && i_space) begin
            r_mode <= n_mode; r_win <= n_win; r_len <= n_len; r_start <= n_start;
            r_held <= n_held; r_star <= n_star; r_row <= n_row; r_pos <= n_pos;
        end
    end

endmodule

// ----- hw/rtl/cmbt_back.sv -----
module cmbt_back import cmbt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pair i_pair,
    output logic  o_space,
    output logic  o_valid,
    input  logic  i_ready,
    output t_tok  o_tok
);

    t_tok             r_q [QDEPTH];
    logic [QBITS-1:0] r_wp, r_rp;
    logic [QBITS:0]   r_cnt;
    logic             pop;
    logic [QBITS:0]   n_add;

    // space for two tokens, one full beat, keeps the front from ever overrunning
    assign o_space = r_cnt <= (QBITS+1)'(QDEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_tok   = r_q[r_rp];
    assign pop     = o_valid && i_ready;
    assign n_add   = i_push ? (QBITS+1)'(i_pair.cnt) : '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_pair.t0;
            if (i_pair.cnt == 2'd2) r_q[r_wp + QBITS'(1)] <= i_pair.t1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + n_add[QBITS-1:0];
            r_rp  <= r_rp + QBITS'(pop);
            r_cnt <= r_cnt + n_add - (QBITS+1)'(pop);
        end
    end

endmodule
